[hdl/ordered_list_engine_macros.svh]
// Shared assertion macros for the ordered list engine.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define OLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ole_pkg.sv]
package ole_pkg;

    // Default list capacity.
    localparam int CAPACITY_DEF = 16;

    // Field widths of one request and one result.
    localparam int FUNC_W   = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int REPORT_W = 5;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_VALUE = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SEARCH    = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

[hdl/ordered_list_engine.sv]
// Ordered list engine: one request at a time, walked through a list memory with one write and one read port.
// Each entry compared or moved passes a read state and a compare or write state; each request ends in S_FINISH.
// A new request is taken only in S_IDLE; a stalled earlier result holds the engine in S_FINISH.
// The next request is taken while a finished result still waits on the output register.
// Reset (rst_n low, asynchronous) empties the list and clears the output valid.
// List storage is not cleared; the values of entries past the count are never used.
module ordered_list_engine
    import ole_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [FUNC_W-1:0]          func,
    input  logic signed [WORD_W-1:0]   value,
    input  logic [POS_W-1:0]           position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [REPORT_W-1:0]        found_at,
    output logic [REPORT_W-1:0]        count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > POS_W) ? CW : POS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_CHK  = 3'd1;
    localparam logic [2:0] S_INS_MOVE = 3'd2;
    localparam logic [2:0] S_DEL_CHK  = 3'd3;
    localparam logic [2:0] S_DEL_MOVE = 3'd4;
    localparam logic [2:0] S_SCAN_RD  = 3'd5;
    localparam logic [2:0] S_SCAN_CMP = 3'd6;
    localparam logic [2:0] S_FINISH   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [WORD_W-1:0]   value_reg, value_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [STATUS_W-1:0] st_reg, st_next;
    logic [REPORT_W-1:0] found_reg, found_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [REPORT_W-1:0] out_found_reg, out_found_next;
    logic [REPORT_W-1:0] out_count_reg, out_count_next;

    logic [CW-1:0]       ptr_inc, ptr_dec, pos_idx;
    logic [WW-1:0]       pos_w, pos_m1_w, cnt_w, ptr_inc_w;
    logic                list_full, list_empty, accept, out_free;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_wdata, ram_rdata;

    ole_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared pointer arithmetic and request decode helpers.
    assign ptr_inc    = ptr_reg + 1'b1;
    assign ptr_dec    = ptr_reg - 1'b1;
    assign ptr_inc_w  = WW'(ptr_inc);
    assign list_full  = (cnt_reg == CW'(CAPACITY));
    assign list_empty = (cnt_reg == '0);
    assign pos_w      = WW'(position);
    assign cnt_w      = WW'(cnt_reg);
    assign pos_m1_w   = (pos_w == '0) ? '0 : (pos_w - 1'b1);
    assign pos_idx    = (pos_m1_w > cnt_w) ? cnt_reg : CW'(pos_m1_w);

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Memory port selection: the write always lands at the pointer.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = ram_rdata;
        ram_waddr = ptr_reg[AW-1:0];
        ram_raddr = ptr_reg[AW-1:0];
        unique case (state_reg)
            S_INS_CHK:
            begin
                ram_raddr = ptr_dec[AW-1:0];
                if (ptr_reg == idx_reg)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = value_reg;
                end
            end
            S_INS_MOVE, S_DEL_MOVE:
            begin
                ram_we = 1'b1;
            end
            S_DEL_CHK:
            begin
                ram_raddr = ptr_inc[AW-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        value_next = value_reg;
        idx_next   = idx_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        found_next = found_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    value_next = value;
                    st_next    = ST_OK;
                    found_next = '0;
                    state_next = S_FINISH;
                    unique case (func) inside
                        FN_INS_FRONT, FN_INS_BACK, FN_INS_POS:
                        begin
                            if (list_full)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                if (func == FN_INS_FRONT)
                                begin
                                    idx_next = '0;
                                end
                                else if (func == FN_INS_BACK)
                                begin
                                    idx_next = cnt_reg;
                                end
                                else
                                begin
                                    idx_next = pos_idx;
                                end
                                ptr_next   = cnt_reg;
                                state_next = S_INS_CHK;
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_BACK:
                        begin
                            if (list_empty)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = (func == FN_DEL_FRONT) ? '0 : (cnt_reg - 1'b1);
                                state_next = S_DEL_CHK;
                            end
                        end
                        FN_DEL_VALUE, FN_SEARCH:
                        begin
                            if (list_empty)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            // Move entries one place back until the gap reaches the target.
            S_INS_CHK:
            begin
                if (ptr_reg == idx_reg)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_INS_MOVE;
                end
            end
            S_INS_MOVE:
            begin
                ptr_next   = ptr_dec;
                state_next = S_INS_CHK;
            end
            // Close the gap by moving later entries one place forward.
            S_DEL_CHK:
            begin
                if (ptr_inc == cnt_reg)
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DEL_MOVE;
                end
            end
            S_DEL_MOVE:
            begin
                ptr_next   = ptr_inc;
                state_next = S_DEL_CHK;
            end
            // Linear scan for the first matching entry.
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (ram_rdata == value_reg)
                begin
                    if (func_reg == FN_SEARCH)
                    begin
                        found_next = ptr_inc_w[REPORT_W-1:0];
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_DEL_CHK;
                    end
                end
                else if (ptr_inc == cnt_reg)
                begin
                    st_next    = ST_NOTFOUND;
                    state_next = S_FINISH;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: loaded at the end of a request, cleared when taken.
    always_comb
    begin
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;
        if ((state_reg == S_FINISH) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = st_reg;
            out_found_next  = found_reg;
            out_count_next  = cnt_w[REPORT_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        ptr_reg        <= ptr_next;
        st_reg         <= st_next;
        found_reg      <= found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign found_at  = out_found_reg;
    assign count     = out_count_reg;

endmodule

[hdl/ole_ram.sv]
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/ole_checker.sv]
`include "ordered_list_engine_macros.svh"

module ole_checker
    import ole_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [STATUS_W-1:0]      status,
    input logic [REPORT_W-1:0]      found_at,
    input logic [REPORT_W-1:0]      count
);

    logic held;

    // A result is held back when it is offered and stalled.
    assign held = out_valid && out_stall;

    // A result that is held back stays offered.
    `OLE_ASSERT_NEXT(a_out_hold, held, out_valid, "result dropped while stalled")

    // A held-back result keeps its fields.
    `OLE_ASSERT_NEXT(a_out_stable, held, $stable({status, found_at, count}), "held result changed")

    // A request always keeps the engine busy for at least the next cycle.
    `OLE_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "engine free after request")

    // A nonzero position is only reported by a successful search.
    `OLE_ASSERT_SAME(a_found_ok, out_valid && (found_at != '0), status == ST_OK, "position with error")

endmodule

bind ordered_list_engine ole_checker u_ole_checker (.*);

[bench/tb.sv]
module tb;
    import ole_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int PHASE_LEN      = 40;
    localparam int DRAIN_CYCLES   = 2 * CAPACITY_DEF + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    // Code 7 is not an operation; the block must answer it without touching the list.
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] value;
        logic [POS_W-1:0]         position;
    } list_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [REPORT_W-1:0] found_at;
        logic [REPORT_W-1:0] count;
    } list_result_t;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [FUNC_W-1:0]         func = FN_INS_FRONT;
    logic signed [WORD_W-1:0]  value = '0;
    logic [POS_W-1:0]          position = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic [REPORT_W-1:0]       found_at;
    logic [REPORT_W-1:0]       count;

    list_request_t             pending_requests[$];
    list_result_t              expected_results[$];
    logic signed [WORD_W-1:0]  shadow_list[$];
    int                        n_fail = 0;

    ordered_list_engine #(
        .CAPACITY (CAPACITY_DEF)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .found_at  (found_at),
        .count     (count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Applies one request to the shadow list and returns the result the block must give.
    function automatic list_result_t apply_list_op(list_request_t r);
        list_result_t res;
        int           idx;
        int           hit;
        res.status   = ST_OK;
        res.found_at = '0;
        case (r.func)
            FN_INS_FRONT, FN_INS_BACK, FN_INS_POS:
            begin
                if (shadow_list.size() >= CAPACITY_DEF)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    if (r.func == FN_INS_FRONT)
                        idx = 0;
                    else if (r.func == FN_INS_BACK)
                        idx = shadow_list.size();
                    else
                        idx = (r.position == '0) ? 0 : int'(r.position) - 1;
                    // A position past the end appends.
                    if (idx > shadow_list.size())
                        idx = shadow_list.size();
                    shadow_list.insert(idx, r.value);
                end
            end
            FN_DEL_FRONT, FN_DEL_BACK:
            begin
                if (shadow_list.size() == 0)
                    res.status = ST_EMPTY;
                else if (r.func == FN_DEL_FRONT)
                    shadow_list.delete(0);
                else
                    shadow_list.delete(shadow_list.size() - 1);
            end
            FN_DEL_VALUE, FN_SEARCH:
            begin
                if (shadow_list.size() == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    hit = -1;
                    for (int i = 0; i < shadow_list.size() && hit < 0; i++)
                    begin
                        if (shadow_list[i] == r.value)
                            hit = i;
                    end
                    if (hit < 0)
                        res.status = ST_NOTFOUND;
                    else if (r.func == FN_DEL_VALUE)
                        shadow_list.delete(hit);
                    else
                        res.found_at = REPORT_W'(hit + 1);
                end
            end
            default:
            begin
            end
        endcase
        res.count = REPORT_W'(shadow_list.size());
        return res;
    endfunction

    task automatic queue_request(logic [FUNC_W-1:0] f, logic signed [WORD_W-1:0] v,
                                 logic [POS_W-1:0] p);
        list_request_t r;
        r.func     = f;
        r.value    = v;
        r.position = p;
        pending_requests.push_back(r);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        list_request_t next_req;
        list_request_t taken_req;
        int            burst_left;
        int            gap_left;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= FN_INS_FRONT;
            value      <= '0;
            position   <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            // A request was taken at this edge; predict its result.
            if (in_valid)
            begin
                taken_req.func     = func;
                taken_req.value    = value;
                taken_req.position = position;
                expected_results.push_back(apply_list_op(taken_req));
            end
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_req = pending_requests.pop_front();
                func     <= next_req.func;
                value    <= next_req.value;
                position <= next_req.position;
                in_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left = burst_left - 1;
                end
                else
                begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each result against the oldest prediction and drives the stall.
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_res;
        stall_mode_e  stall_mode;
        int           mode_left;
        int           stall_period;
        int           stall_phase;
        logic         next_stall;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            stall_mode   = STALL_NONE;
            mode_left    = 0;
            stall_period = 2;
            stall_phase  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d found_at %0d count %0d",
                           status, found_at, count);
                    n_fail++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (status !== exp_res.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
                        n_fail++;
                    end
                    if (found_at !== exp_res.found_at)
                    begin
                        $error("found_at mismatch: expected %0d, actual %0d",
                               exp_res.found_at, found_at);
                        n_fail++;
                    end
                    if (count !== exp_res.count)
                    begin
                        $error("count mismatch: expected %0d, actual %0d", exp_res.count, count);
                        n_fail++;
                    end
                end
            end

            // Switch to a new stall pattern, with a random length and period, once the current one runs out.
            if (mode_left == 0)
            begin
                stall_mode   = stall_mode_e'($urandom_range(0, 3));
                mode_left    = $urandom_range(16, 96);
                stall_period = $urandom_range(2, 9);
                stall_phase  = 0;
            end
            else
            begin
                mode_left = mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:
                    next_stall = 1'b0;
                STALL_RANDOM:
                    next_stall = 1'($urandom_range(0, 1));
                STALL_PERIODIC:
                begin
                    next_stall  = (stall_phase < stall_period / 2);
                    stall_phase = (stall_phase + 1) % stall_period;
                end
                default:
                    next_stall = ($urandom_range(0, 9) < 8);
            endcase
            out_stall <= next_stall;
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        int idle_cycles;
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
        end
    end

    // Stimulus: a directed opening, then phases that favor filling, draining or a mix.
    initial
    begin
        logic signed [WORD_W-1:0] value_pool[8];
        list_request_t            r;
        int                       ins_pct;
        int                       roll;

        // Every search and delete request, and the unused code, against an empty list.
        queue_request(FN_SEARCH, 32'sd7, 5'd1);
        queue_request(FN_DEL_FRONT, 32'sd0, 5'd1);
        queue_request(FN_DEL_BACK, 32'sd0, 5'd1);
        queue_request(FN_DEL_VALUE, 32'sd7, 5'd1);
        queue_request(FN_UNUSED, 32'sd7, 5'd1);
        // Positional insert into an empty list, then the extremes of value and position.
        queue_request(FN_INS_POS, 32'sd5, 5'd5);
        queue_request(FN_INS_FRONT, 32'sh8000_0000, 5'd1);
        queue_request(FN_INS_BACK, 32'sh7FFF_FFFF, 5'd1);
        queue_request(FN_INS_POS, -32'sd1, 5'd0);
        queue_request(FN_INS_POS, 32'sd0, 5'd31);
        queue_request(FN_INS_POS, 32'sh5555_5555, 5'd2);
        queue_request(FN_INS_POS, 32'shAAAA_AAAA, 5'd16);
        queue_request(FN_UNUSED, 32'sd0, 5'd0);
        // Hits, misses and a duplicate where the first match must win.
        queue_request(FN_SEARCH, 32'sh8000_0000, 5'd1);
        queue_request(FN_SEARCH, 32'sh7FFF_FFFF, 5'd1);
        queue_request(FN_SEARCH, 32'sd12345, 5'd1);
        queue_request(FN_DEL_VALUE, 32'sd12345, 5'd1);
        queue_request(FN_INS_FRONT, 32'sd0, 5'd1);
        queue_request(FN_SEARCH, 32'sd0, 5'd1);
        queue_request(FN_DEL_VALUE, 32'sd0, 5'd1);
        queue_request(FN_SEARCH, 32'sd0, 5'd1);
        queue_request(FN_DEL_VALUE, -32'sd1, 5'd1);
        queue_request(FN_DEL_FRONT, 32'sd0, 5'd1);
        queue_request(FN_DEL_BACK, 32'sd0, 5'd1);

        // A small pool of words so that deletes and searches often hit.
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (int k = 4; k < 8; k++)
            value_pool[k] = $urandom;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case ((n / PHASE_LEN) % 3)
                0:       ins_pct = 75;
                1:       ins_pct = 20;
                default: ins_pct = 50;
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                r.func = FN_UNUSED;
            end
            else if (roll < ins_pct)
            begin
                case ($urandom_range(0, 2))
                    0:       r.func = FN_INS_FRONT;
                    1:       r.func = FN_INS_BACK;
                    default: r.func = FN_INS_POS;
                endcase
            end
            else if (roll < ins_pct + (100 - ins_pct) / 2)
            begin
                case ($urandom_range(0, 2))
                    0:       r.func = FN_DEL_FRONT;
                    1:       r.func = FN_DEL_BACK;
                    default: r.func = FN_DEL_VALUE;
                endcase
            end
            else
            begin
                r.func = FN_SEARCH;
            end
            r.value = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
            r.position = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 31))
                                                     : POS_W'($urandom_range(1, 16));
            pending_requests.push_back(r);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge so the driver and monitor have settled.
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
